@@ src/tws_pkg.sv @@
// Package for the text window scroller: sizes, constants and the
// command and status records between the controller and the datapath.
// No dependencies.
package tws_pkg;

	localparam int WINDOW_WIDTH = 16;
	localparam int TEXT_DEPTH   = 128;

	localparam int ADDR_W = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
	localparam int LEN_W  = ADDR_W + 1;
	localparam int POS_W  = (WINDOW_WIDTH > 1) ? $clog2(WINDOW_WIDTH) : 1;
	localparam int OFS_W  = ((ADDR_W > POS_W) ? ADDR_W : POS_W) + 2;

	localparam int CHAR_W   = 8;
	localparam int IDX_W    = 7;
	localparam int CPOS_W   = 4;
	localparam int PERIOD_W = 16;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;
	localparam logic [CHAR_W-1:0]   SPACE_CODE   = 8'h20;

	localparam logic REQ_TICK  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	typedef struct packed {
		logic acc;
		logic scan_init;
		logic scan_next;
		logic len_here;
		logic len_full;
		logic wrap;
		logic emit_rd;
		logic emit_load;
	} cmd_t;

	typedef struct packed {
		logic step_hit;
		logic scan_zero;
		logic scan_end;
		logic out_free;
		logic pos_last;
	} sts_t;

endpackage

@@ src/tws_if.sv @@
// Channel interfaces of the text window scroller: request words in,
// character words out. Depends on tws_pkg.
interface tws_req_if import tws_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [IDX_W-1:0]  char_index;
	logic [CHAR_W-1:0] char_value;

	modport source(output valid, req_type, char_index, char_value, input ready);
	modport sink(input valid, req_type, char_index, char_value, output ready);
endinterface

interface tws_chr_if import tws_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic [CPOS_W-1:0] char_pos;
	logic              last_char;

	modport source(output valid, char_code, char_pos, last_char, input ready);
	modport sink(input valid, char_code, char_pos, last_char, output ready);
endinterface

@@ src/tws_ctrl.sv @@
// Controller of the text window scroller: sequences the length scan and
// the window emission. Depends on tws_pkg.
module tws_ctrl import tws_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_req_type,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN0 = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_WRAP  = 3'd3;
	localparam logic [2:0] ST_ERD   = 3'd4;
	localparam logic [2:0] ST_EWR   = 3'd5;

	logic [2:0] state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.acc = 1'b1;
					if (in_req_type == REQ_TICK && sts.step_hit)
						state_d = ST_SCAN0;
				end
			end
			ST_SCAN0: begin
				cmd.scan_init = 1'b1;
				state_d       = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.scan_zero) begin
					cmd.len_here = 1'b1;
					state_d      = ST_WRAP;
				end else if (sts.scan_end) begin
					cmd.len_full = 1'b1;
					state_d      = ST_WRAP;
				end else begin
					cmd.scan_next = 1'b1;
				end
			end
			ST_WRAP: begin
				cmd.wrap = 1'b1;
				state_d  = ST_ERD;
			end
			ST_ERD: begin
				cmd.emit_rd = 1'b1;
				state_d     = ST_EWR;
			end
			ST_EWR: begin
				if (sts.out_free) begin
					cmd.emit_load = 1'b1;
					state_d       = sts.pos_last ? ST_IDLE : ST_ERD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

@@ src/tws_dp.sv @@
// Datapath of the text window scroller: text store with valid bits, tick
// counter, scroll offset, length scan and output register. Depends on tws_pkg.
module tws_dp import tws_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  logic                req_type,
	input  logic [IDX_W-1:0]    char_index,
	input  logic [CHAR_W-1:0]   char_value,
	input  logic                cfg_we,
	input  logic [PERIOD_W-1:0] cfg_wdata,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [CHAR_W-1:0]   char_code,
	output logic [CPOS_W-1:0]   char_pos,
	output logic                last_char
);

	localparam logic signed [OFS_W-1:0] OFS_INIT = OFS_W'(-WINDOW_WIDTH);

	logic [CHAR_W-1:0]   mem [TEXT_DEPTH];
	logic [TEXT_DEPTH-1:0] vld_q;
	logic [CHAR_W-1:0]   rd_data_q;
	logic                rd_vld_q;
	logic [PERIOD_W-1:0] period_q, countdown_q, cd_next;
	logic signed [OFS_W-1:0] offset_q, src, len_s;
	logic [LEN_W-1:0]    len_q;
	logic [ADDR_W-1:0]   chk_q, rd_addr, wr_addr;
	logic [POS_W-1:0]    pos_q;
	logic [7:0]          pos_ext;
	logic                in_text, in_text_q, rd_en, wr_en;
	logic [CHAR_W-1:0]   rd_byte;
	logic                out_valid_q, out_last_q;
	logic [CHAR_W-1:0]   out_code_q;
	logic [CPOS_W-1:0]   out_pos_q;

	always_comb begin
		cd_next = (countdown_q == '0) ? '0 : countdown_q - PERIOD_W'(1);
		wr_en   = cmd.acc && (req_type == REQ_WRITE) && (32'(char_index) < TEXT_DEPTH);
		wr_addr = ADDR_W'(char_index);
		rd_en   = cmd.scan_init || cmd.scan_next || cmd.emit_rd;
		len_s   = OFS_W'(len_q);
		src     = offset_q + OFS_W'(pos_q);
		in_text = !src[OFS_W-1] && (src < len_s);
		if (cmd.scan_init)
			rd_addr = '0;
		else if (cmd.scan_next)
			rd_addr = chk_q + ADDR_W'(1);
		else
			rd_addr = src[ADDR_W-1:0];
		rd_byte = rd_vld_q ? rd_data_q : '0;
		pos_ext = 8'(pos_q);

		sts.step_hit  = (period_q != '0) && (cd_next == '0);
		sts.scan_zero = (rd_byte == '0);
		sts.scan_end  = (chk_q == ADDR_W'(TEXT_DEPTH - 1));
		sts.out_free  = !out_valid_q || out_ready;
		sts.pos_last  = (pos_q == POS_W'(WINDOW_WIDTH - 1));
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= char_value;
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			rd_vld_q    <= 1'b0;
			period_q    <= PERIOD_RESET;
			countdown_q <= PERIOD_RESET;
			offset_q    <= OFS_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en)
				vld_q[wr_addr] <= 1'b1;
			if (rd_en)
				rd_vld_q <= vld_q[rd_addr];
			if (cfg_we)
				period_q <= cfg_wdata;
			if (cmd.acc && req_type == REQ_TICK)
				countdown_q <= sts.step_hit ? period_q : cd_next;
			if (cmd.wrap && offset_q >= len_s)
				offset_q <= OFS_INIT;
			else if (cmd.emit_load && sts.pos_last)
				offset_q <= offset_q + OFS_W'(1);
			if (cmd.emit_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_init)
			chk_q <= '0;
		else if (cmd.scan_next)
			chk_q <= chk_q + ADDR_W'(1);
		if (cmd.len_here)
			len_q <= {1'b0, chk_q};
		else if (cmd.len_full)
			len_q <= LEN_W'(TEXT_DEPTH);
		if (cmd.emit_rd)
			in_text_q <= in_text;
		if (cmd.wrap)
			pos_q <= '0;
		else if (cmd.emit_load)
			pos_q <= pos_q + POS_W'(1);
		if (cmd.emit_load) begin
			out_code_q <= in_text_q ? rd_byte : SPACE_CODE;
			out_pos_q  <= pos_ext[CPOS_W-1:0];
			out_last_q <= sts.pos_last;
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = out_code_q;
	assign char_pos  = out_pos_q;
	assign last_char = out_last_q;

endmodule

@@ src/text_window_scroller.sv @@
// Top level of the text window scroller: joins the controller and the
// datapath to the channel interfaces. Depends on tws_pkg, tws_if, tws_ctrl, tws_dp.
//
// Use: request words arrive on req. A write word stores char_value at
// char_index in the 128-byte text store; a tick word counts the period
// counter down. When the counter reaches zero with a nonzero scroll_period,
// the counter reloads and the block emits one window of 16 character words
// on disp, left to right, with last_char set on the final one, then moves
// the scroll offset by one. The user writes scroll_period through cfg_we and
// cfg_wdata while the block is idle; the block does not enforce this.
// Operation: a write word or a tick that causes no step leaves the block idle.
// A step scans the store serially for the text end, one byte a cycle over
// the single read port, then reads and loads each window position in turn.
// req.ready is low during a step; the last word may still wait in the output
// register while new request words are taken.
// Reset clears the store to zeros through per-entry valid bits, loads 1000
// into the period and the counter, and places the window left of the text.
// When disp stalls, emission waits with the word held in the output register.
module text_window_scroller import tws_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	tws_req_if.sink             req,
	tws_chr_if.source           disp,
	input  logic                cfg_we,
	input  logic [PERIOD_W-1:0] cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	tws_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req.valid),
		.in_req_type (req.req_type),
		.in_ready    (req.ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	tws_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.req_type   (req.req_type),
		.char_index (req.char_index),
		.char_value (req.char_value),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.out_ready  (disp.ready),
		.out_valid  (disp.valid),
		.char_code  (disp.char_code),
		.char_pos   (disp.char_pos),
		.last_char  (disp.last_char)
	);

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		disp.valid && disp.last_char |->
			disp.char_pos == CPOS_W'(WINDOW_WIDTH - 1))
		else $error("last_char on a position other than the window end");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_load |-> !disp.valid || disp.ready)
		else $error("output word overwritten before it was taken");

	a_busy_after_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(req.ready) |-> $past(req.valid && req.req_type == REQ_TICK))
		else $error("scroll step started without a tick word");

endmodule

@@ tb/sv/tb_text_window_scroller.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for text_window_scroller: drives request words and
// period writes, predicts every window of char words, and checks them in order.
// Depends on tws_pkg, tws_if and the block itself.
module tb_text_window_scroller;
	import tws_pkg::*;

	localparam int SETTLE_CYCLES  = 8;
	localparam int TAIL_CYCLES    = 200;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASES         = 6;
	localparam int PHASE_WORDS    = 35;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic [CPOS_W-1:0] pos;
		logic              last_flag;
	} char_word_t;

	typedef enum logic [1:0] {ROW_CFG, ROW_WRITE, ROW_TICK, ROW_BLANK} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		logic [IDX_W-1:0]  idx;
		logic [15:0]       arg;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [PERIOD_W-1:0] cfg_wdata;

	tws_req_if req_ch();
	tws_chr_if disp_ch();

	text_window_scroller u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.disp(disp_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	logic [PERIOD_W-1:0] period_q;
	logic [PERIOD_W-1:0] count_q;
	int                  offset_q;
	logic [CHAR_W-1:0]   store_q [TEXT_DEPTH];
	char_word_t          pending_chars [$];
	int                  errors = 0;
	int                  req_count = 0;
	int                  quiet_cycles = 0;
	bit                  calm = 1'b0;
	bit                  hold_req = 1'b0;

	// Directed plan; a blank row is a tick on empty text, so a step shows a blank window.
	row_t plan [24] = '{
		'{ROW_CFG,   7'd0,   16'd1},
		'{ROW_BLANK, 7'd0,   16'd0},
		'{ROW_BLANK, 7'd0,   16'd0},
		'{ROW_WRITE, 7'd0,   16'h48},
		'{ROW_WRITE, 7'd1,   16'h7E},
		'{ROW_WRITE, 7'd2,   16'h00},
		'{ROW_TICK,  7'd0,   16'd0},
		'{ROW_WRITE, 7'd127, 16'hFF},
		'{ROW_WRITE, 7'd3,   16'h01},
		'{ROW_WRITE, 7'd2,   16'h80},
		'{ROW_TICK,  7'd0,   16'd0},
		'{ROW_TICK,  7'd0,   16'd0},
		'{ROW_WRITE, 7'd0,   16'h00},
		'{ROW_BLANK, 7'd0,   16'd0},
		'{ROW_CFG,   7'd0,   16'd0},
		'{ROW_TICK,  7'd0,   16'd0},
		'{ROW_TICK,  7'd0,   16'd0},
		'{ROW_WRITE, 7'd0,   16'h41},
		'{ROW_CFG,   7'd0,   16'd1},
		'{ROW_TICK,  7'd0,   16'd0},
		'{ROW_CFG,   7'd0,   16'd2},
		'{ROW_TICK,  7'd0,   16'd0},
		'{ROW_TICK,  7'd0,   16'd0},
		'{ROW_TICK,  7'd0,   16'd0}
	};

	int phase_period [PHASES] = '{1, 3, 1, 0, 2, 1};

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic bit tick_due();
		if (count_q != 0)
			count_q--;
		if (period_q != 0 && count_q == 0) begin
			count_q = period_q;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void scroll_window(input bit blank);
		int         len;
		int         first;
		int         cnt;
		int         lead;
		int         rel;
		int         p;
		char_word_t w;
		len = 0;
		while (len < TEXT_DEPTH && store_q[len] != 0)
			len++;
		if (offset_q >= len)
			offset_q = -WINDOW_WIDTH;
		first = (offset_q < 0) ? 0 : offset_q;
		cnt = (offset_q < 0) ? WINDOW_WIDTH + offset_q : WINDOW_WIDTH;
		if (cnt > len - first)
			cnt = len - first;
		if (cnt < 0)
			cnt = 0;
		lead = (offset_q < 0) ? -offset_q : 0;
		for (p = 0; p < WINDOW_WIDTH; p++) begin
			rel = p - lead;
			w.code = SPACE_CODE;
			if (!blank && rel >= 0 && rel < cnt)
				w.code = store_q[first + rel];
			w.pos = CPOS_W'(p);
			w.last_flag = (p == WINDOW_WIDTH - 1);
			pending_chars.push_back(w);
		end
		offset_q++;
	endfunction

	task automatic send_word(input logic kind, input logic [IDX_W-1:0] idx,
			input logic [CHAR_W-1:0] value, input bit blank);
		int gap;
		gap = (calm || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 15);
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.char_index <= idx;
		req_ch.char_value <= value;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		req_count++;
		if (kind == REQ_WRITE)
			store_q[idx] = value;
		else if (tick_due())
			scroll_window(blank);
	endtask

	task automatic send_tick();
		send_word(REQ_TICK, '0, '0, 1'b0);
	endtask

	task automatic send_char(input int idx, input int value);
		send_word(REQ_WRITE, IDX_W'(idx), CHAR_W'(value), 1'b0);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_period(input logic [PERIOD_W-1:0] value);
		wait_drained();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		period_q = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : sink_side
		int burst;
		disp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				burst = HOLD_CYCLES;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(1, 15);
			end else begin
				burst = 0;
			end
			if (burst > 0) begin
				disp_ch.ready <= 1'b0;
				repeat (burst) @(negedge clk);
			end
			disp_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : char_check
		char_word_t want;
		if (arst_n === 1'b1 && disp_ch.valid === 1'b1 && disp_ch.ready === 1'b1) begin
			if (pending_chars.size() == 0) begin
				$error("unexpected char word: char_code %02h char_pos %0d",
					disp_ch.char_code, disp_ch.char_pos);
				errors++;
			end else begin
				want = pending_chars.pop_front();
				if (disp_ch.char_code !== want.code) begin
					$error("char_code: expected %02h, actual %02h", want.code,
						disp_ch.char_code);
					errors++;
				end
				if (disp_ch.char_pos !== want.pos) begin
					$error("char_pos: expected %0d, actual %0d", want.pos, disp_ch.char_pos);
					errors++;
				end
				if (disp_ch.last_char !== want.last_flag) begin
					$error("last_char: expected %0b, actual %0b", want.last_flag,
						disp_ch.last_char);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(disp_ch.valid === 1'b1 && disp_ch.ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		int ph;
		int k;
		int len;
		int phase_end;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_TICK;
		req_ch.char_index = '0;
		req_ch.char_value = '0;
		period_q = PERIOD_RESET;
		count_q = PERIOD_RESET;
		offset_q = -WINDOW_WIDTH;
		foreach (store_q[k])
			store_q[k] = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// With scrolling stopped, run the counter down from its reset value to one.
		set_period('0);
		while (count_q != 1)
			send_tick();

		foreach (plan[k]) begin
			case (plan[k].kind)
				ROW_CFG:   set_period(plan[k].arg);
				ROW_WRITE: send_word(REQ_WRITE, plan[k].idx, plan[k].arg[CHAR_W-1:0], 1'b0);
				ROW_TICK:  send_tick();
				ROW_BLANK: send_word(REQ_TICK, '0, '0, 1'b1);
				default:   ;
			endcase
		end

		for (ph = 0; ph < PHASES; ph++) begin
			set_period(PERIOD_W'(phase_period[ph]));
			calm = (ph == PHASES - 1);
			if (ph == 0) begin
				// The display stalls for a long stretch while ticks keep coming.
				hold_req = 1'b1;
				send_char(0, 0);
				repeat (WINDOW_WIDTH + 2) send_tick();
			end
			if (ph == 2) begin
				for (k = 0; k < TEXT_DEPTH; k++)
					send_char(k, $urandom_range(1, 255));
				repeat (20) send_tick();
			end
			phase_end = req_count + PHASE_WORDS;
			while (req_count < phase_end) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: begin
						len = $urandom_range(0, 20);
						for (k = 0; k < len; k++)
							send_char(k, $urandom_range(1, 255));
						send_char(len, 0);
						repeat ($urandom_range(1, 12)) send_tick();
					end
					5, 6: repeat ($urandom_range(1, 8)) send_tick();
					7: send_char($urandom_range(0, TEXT_DEPTH - 1), $urandom_range(0, 255));
					8: send_char($urandom_range(0, 20), 0);
					default: begin
						send_char($urandom_range(0, TEXT_DEPTH - 1), $urandom_range(0, 255));
						send_tick();
					end
				endcase
			end
		end

		set_period('1);
		while (count_q != '1)
			send_tick();
		repeat (2) send_tick();

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_chars.size() != 0) begin
			$error("%0d char words never arrived", pending_chars.size());
			errors++;
		end
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
src/tws_pkg.sv
src/tws_if.sv
src/tws_ctrl.sv
src/tws_dp.sv
src/text_window_scroller.sv
tb/sv/tb_text_window_scroller.sv
